FILE: sv/frtc_pkg.sv
// frtc_pkg: shared types and constants of the flow rule table classifier
// holds the queue word, the rule entry layout and the result word
// no dependencies; imported by every module of the block

package frtc_pkg;

	localparam int unsigned ADDR_W          = 32;
	localparam int unsigned PORT_W          = 17;
	localparam int unsigned PROTO_W         = 8;
	localparam int unsigned ACT_W           = 2;
	localparam int unsigned MAX_RULES_DEF   = 16;

	localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
	localparam logic [PORT_W-1:0]  SSH_PORT  = 17'd22;
	localparam logic [PORT_W-1:0]  PORT_ANY  = 17'h1FFFF;
	localparam logic [ADDR_W-1:0]  ADDR_ANY  = 32'h0000_0000;
	localparam logic [ADDR_W-1:0]  LOOPBACK  = 32'h7F00_0001;

	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_WRITE    = 1'b1;

	localparam logic MODE_ACCEPT = 1'b0;
	localparam logic MODE_DROP   = 1'b1;

	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CAPTURE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_INSPECT = 2'd2;
	localparam logic [ACT_W-1:0] ACT_IGNORE  = 2'd3;

	// what the front decided about a word
	typedef enum logic [1:0] {
		KIND_PASS   = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_WRITE  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] sa;
		logic [ADDR_W-1:0] da;
		logic [PORT_W-1:0] sp;
		logic [PORT_W-1:0] dp;
		logic              mode;
		logic [ACT_W-1:0]  act;
		logic              sig;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic [ADDR_W-1:0] sa;
		logic [ADDR_W-1:0] da;
		logic [PORT_W-1:0] sp;
		logic [PORT_W-1:0] dp;
		logic              mode;
		logic [ACT_W-1:0]  act;
	} entry_t;

	typedef struct packed {
		logic done;
		logic verdict;
		logic capture;
		logic matched;
		logic status;
	} result_t;

endpackage

FILE: sv/frtc_front.sv
// frtc_front: takes words in, sorts them into pass, lookup or rule write
// and holds them in a two-entry queue until the scan engine pops them
// depends on frtc_pkg

module frtc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [frtc_pkg::PROTO_W-1:0]  protocol,
	input  logic [frtc_pkg::ADDR_W-1:0]   src_addr,
	input  logic [frtc_pkg::ADDR_W-1:0]   dst_addr,
	input  logic [frtc_pkg::PORT_W-1:0]   src_prt,
	input  logic [frtc_pkg::PORT_W-1:0]   dst_prt,
	input  logic                          rule_mode,
	input  logic [frtc_pkg::ACT_W-1:0]    rule_action,
	input  logic                          signature_hit,
	output frtc_pkg::qhead_t              head,
	input  logic                          pop
);
	import frtc_pkg::*;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	item_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	item_t               item_in;
	logic                push;
	logic                do_pop;

	always_comb begin
		item_in.sa   = src_addr;
		item_in.da   = dst_addr;
		item_in.sp   = src_prt;
		item_in.dp   = dst_prt;
		item_in.mode = rule_mode;
		item_in.act  = rule_action;
		item_in.sig  = signature_hit;
		if (cmd == CMD_WRITE) begin
			item_in.kind = KIND_WRITE;
		end else if (protocol != PROTO_TCP || dst_prt == SSH_PORT) begin
			item_in.kind = KIND_PASS;
		end else begin
			item_in.kind = KIND_LOOKUP;
		end
	end

	assign busy   = (cnt_q == QCNT_W'(QDEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/frtc_back.sv
// frtc_back: rule table memory and the scan engine that walks it newest first
// one read issued per cycle, compare on the registered read data
// depends on frtc_pkg

module frtc_back #(
	parameter int unsigned MAX_RULES = frtc_pkg::MAX_RULES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frtc_pkg::qhead_t  head,
	output logic              pop,
	output frtc_pkg::result_t res
);
	import frtc_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_RULES);
	localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	item_t              work_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   idx_q;
	logic               issue_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	entry_t             rd_ent_s1;
	logic               mode0_q;
	logic [ACT_W-1:0]   act0_q;
	result_t            res_q;
	entry_t             mem [MAX_RULES];

	entry_t             ent;
	logic               tuple_eq;
	logic               rule_hit;
	logic               hit;
	logic               last;
	logic               finish;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_ent;
	logic               cnt_inc;
	result_t            res_d;

	assign cnt_m1 = cnt_q - 1'b1;

	// entry 0 keeps its reset four-tuple forever; only mode and action move
	always_comb begin
		if (rd_idx_s1 == '0) begin
			ent.sa   = LOOPBACK;
			ent.da   = LOOPBACK;
			ent.sp   = PORT_ANY;
			ent.dp   = PORT_ANY;
			ent.mode = mode0_q;
			ent.act  = act0_q;
		end else begin
			ent = rd_ent_s1;
		end
	end

	always_comb begin
		tuple_eq = (ent.sp == work_q.sp) && (ent.sa == work_q.sa)
			&& (ent.dp == work_q.dp) && (ent.da == work_q.da);
		// loopback in a rule matches any destination
		rule_hit = (ent.dp == PORT_ANY || ent.dp == work_q.dp)
			&& (ent.sp == PORT_ANY || ent.sp == work_q.sp)
			&& (ent.sa == ADDR_ANY || ent.sa == work_q.sa)
			&& (ent.da == ADDR_ANY || ent.da == work_q.da || ent.da == LOOPBACK);
		if (work_q.kind == KIND_WRITE) begin
			hit = rd_vld_s1 && tuple_eq;
		end else begin
			hit = rd_vld_s1 && (ent.act != ACT_IGNORE) && rule_hit;
		end
		last   = rd_vld_s1 && (rd_idx_s1 == '0);
		finish = (state_q == S_SCAN) && (hit || last);
	end

	assign pop = (state_q == S_IDLE) && head.valid;

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = rd_idx_s1;
		wr_ent  = ent;
		cnt_inc = 1'b0;
		res_d   = '0;
		if (pop && head.item.kind == KIND_PASS) begin
			res_d.done = 1'b1;
		end else if (finish) begin
			res_d.done = 1'b1;
			if (work_q.kind == KIND_WRITE) begin
				if (hit) begin
					wr_en         = 1'b1;
					wr_ent.mode   = work_q.mode;
					wr_ent.act    = work_q.act;
					res_d.matched = 1'b1;
				end else if (cnt_q < CNT_W'(MAX_RULES)) begin
					wr_en       = 1'b1;
					wr_idx      = cnt_q[IDX_W-1:0];
					wr_ent.sa   = work_q.sa;
					wr_ent.da   = work_q.da;
					wr_ent.sp   = work_q.sp;
					wr_ent.dp   = work_q.dp;
					wr_ent.mode = work_q.mode;
					wr_ent.act  = work_q.act;
					cnt_inc     = 1'b1;
				end else begin
					res_d.status = 1'b1;
				end
			end else if (hit) begin
				res_d.matched = 1'b1;
				if (ent.act == ACT_INSPECT && work_q.sig) begin
					wr_en         = 1'b1;
					wr_ent.mode   = MODE_DROP;
					res_d.verdict = MODE_DROP;
				end else begin
					res_d.verdict = ent.mode;
					res_d.capture = (ent.act == ACT_CAPTURE);
				end
			end else begin
				res_d.verdict = MODE_DROP;
			end
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx != '0) begin
			mem[wr_idx] <= wr_ent;
		end
		rd_ent_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= CNT_W'(1);
			idx_q     <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			mode0_q   <= MODE_ACCEPT;
			act0_q    <= ACT_NONE;
			res_q     <= '0;
		end else begin
			res_q     <= res_d;
			rd_idx_s1 <= idx_q;
			rd_vld_s1 <= (state_q == S_SCAN) && issue_q && !finish;
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (wr_en && wr_idx == '0) begin
				mode0_q <= wr_ent.mode;
				act0_q  <= wr_ent.act;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop && head.item.kind != KIND_PASS) begin
						state_q <= S_SCAN;
						idx_q   <= cnt_m1[IDX_W-1:0];
						issue_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (finish) begin
						state_q <= S_IDLE;
						issue_q <= 1'b0;
					end else if (issue_q) begin
						idx_q <= idx_q - 1'b1;
						if (idx_q == '0) begin
							issue_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res = res_q;

endmodule

FILE: sv/flow_rule_table_classifier.sv
// flow_rule_table_classifier: top level, front queue plus rule scan engine
// a pass-through word (non-tcp or ssh port) goes through a queue slot and the
// result register to done; lookups and rule writes also wait for a table scan,
// which is set by the single table read port walking one rule a cycle
// pass-through words go one per cycle while the scan engine is idle
// reset: async active low; table holds only the loopback rule, queue empty

module flow_rule_table_classifier #(
	parameter int unsigned MAX_RULES = frtc_pkg::MAX_RULES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [frtc_pkg::PROTO_W-1:0]  protocol,
	input  logic [frtc_pkg::ADDR_W-1:0]   src_addr,
	input  logic [frtc_pkg::ADDR_W-1:0]   dst_addr,
	input  logic signed [frtc_pkg::PORT_W-1:0] src_prt,
	input  logic signed [frtc_pkg::PORT_W-1:0] dst_prt,
	input  logic                          rule_mode,
	input  logic [frtc_pkg::ACT_W-1:0]    rule_action,
	input  logic                          signature_hit,
	output logic                          done,
	output logic                          verdict,
	output logic                          capture,
	output logic                          matched,
	output logic                          status
);
	import frtc_pkg::*;

	// queue head seen by the scan engine
	qhead_t  head;
	logic    pop;
	// registered result word, one cycle strobe
	result_t res;

	// front: sorts each word and parks it; busy only when both slots are full,
	// so a word is taken while the scan engine still works on an older one
	frtc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.protocol      (protocol),
		.src_addr      (src_addr),
		.dst_addr      (dst_addr),
		// ports are compared as raw 17-bit patterns
		.src_prt       ($unsigned(src_prt)),
		.dst_prt       ($unsigned(dst_prt)),
		.rule_mode     (rule_mode),
		.rule_action   (rule_action),
		.signature_hit (signature_hit),
		.head          (head),
		.pop           (pop)
	);

	// back: walks the table newest first, one rule per cycle, and applies the
	// update, append or inspect write-back on the cycle it finishes
	frtc_back #(
		.MAX_RULES (MAX_RULES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

	// the receiver takes every result word as it comes
	assign done    = res.done;
	assign verdict = res.verdict;
	assign capture = res.capture;
	assign matched = res.matched;
	assign status  = res.status;

endmodule

FILE: sv/frtc_checker.sv
// frtc_checker: port-level checks of the classifier over time
// bound to flow_rule_table_classifier; depends on frtc_pkg

module frtc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic verdict,
	input logic capture,
	input logic matched,
	input logic status
);
	import frtc_pkg::*;

	// a refused rule write carries no verdict, capture or match
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !verdict && !capture && !matched)
		else $error("status word with other flags set");

	// capture only comes from a rule that matched
	a_capture_matched: assert property (@(posedge clk) disable iff (!arst_n)
		done && capture |-> matched)
		else $error("capture without a matching rule");

	// the queue fills only by taking a word
	a_busy_by_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted word");

	// a capture always goes with a packet verdict, never a refused write
	a_capture_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && capture |-> !status)
		else $error("capture on a rule write word");

endmodule

bind flow_rule_table_classifier frtc_checker u_frtc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.verdict (verdict),
	.capture (capture),
	.matched (matched),
	.status  (status)
);
